/* src/fat32_directory_record_parser_defines.svh */
// Assertion macros shared by the checker.
`ifndef FAT32_DIRECTORY_RECORD_PARSER_DEFINES_SVH
`define FAT32_DIRECTORY_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FDRP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/fdrp_pkg.sv */
package fdrp_pkg;

   localparam logic [4:0] RecLastOffset = 5'd31;
   localparam logic [7:0] MarkDeleted   = 8'hE5;
   localparam logic [7:0] AttrVolume    = 8'h08;
   localparam logic [7:0] AttrLongName  = 8'h0F;
   localparam int unsigned AttrDirBit   = 4;
   localparam logic [7:0] DotChar       = 8'h2E;
   localparam logic [15:0] MaxEntriesReset = 16'd64;
   localparam logic [31:0] ClusterRoot  = 32'd2;

   localparam logic KindEntry = 1'b0;
   localparam logic KindEnd   = 1'b1;

   localparam logic [1:0] DotNone   = 2'd0;
   localparam logic [1:0] DotSingle = 2'd1;
   localparam logic [1:0] DotDouble = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [15:0] entry_index;
      logic        last_entry;
      logic        had_long_name;
      logic [63:0] name_main;
      logic [23:0] name_ext;
      logic [7:0]  attr;
      logic [15:0] cluster_hi;
      logic [15:0] cluster_lo;
      logic [31:0] size_bytes;
   } rec_type;

   typedef struct packed {
      logic [31:0] size_bytes;
      logic [31:0] cluster_head;
      logic [1:0]  dot_kind;
      logic        had_long_name;
      logic        dir_flag;
      logic [23:0] name_ext;
      logic [63:0] name_main;
      logic [15:0] entry_index;
   } rsp_fields_type;

   localparam int unsigned RspDataWidth = (($bits(rsp_fields_type) + 7) / 8) * 8;

endpackage

/* src/fat32_directory_record_parser.sv */
// Channel  Dir  Beat                        Sideband
// req      in   data_byte (8)               tuser = start_listing
// rsp      out  one parsed entry (176)      tuser = kind, tlast = last_entry
// csr      in   max_entries (16)            write enable only
//
// One byte is taken every cycle while the queue is not full; a result passes
// from the byte that closes its 32-byte record through the queue into the output register.
// Reset clears the parse state, the queue and the output register's valid flag.
// req_tready falls only while the front-to-back queue is full, which needs
// the output register held by rsp_tready while QueueDepth further results are pushed.
module fat32_directory_record_parser #(
   parameter int unsigned QueueDepth = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [15:0]                       csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // data_byte
   input  logic                              req_tuser,  // start_listing
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_index, name_main, name_ext, dir_flag, had_long_name,
   // dot_kind, cluster_head, size_bytes, zero fill
   output logic [fdrp_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                              rsp_tuser,  // kind
   output logic                              rsp_tlast   // last_entry
);

   fdrp_pkg::rec_type push_data;
   fdrp_pkg::rec_type head_data;
   logic              q_push, q_full, q_valid, q_pop;

   fdrp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (push_data)
   );

   fdrp_queue #(
      .Depth (QueueDepth),
      .Width ($bits(fdrp_pkg::rec_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .valid     (q_valid),
      .head_data (head_data),
      .pop       (q_pop)
   );

   fdrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (head_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/fdrp_front.sv */
module fdrp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   input  logic [7:0]           req_tdata,
   input  logic                 q_full,
   output logic                 q_push,
   output fdrp_pkg::rec_type    q_push_data
);

   logic [7:0]  rec_ff [32];
   logic [4:0]  offset_ff, offset_in, offset_eff;
   logic        pending_ff, pending_in, pending_eff;
   logic [15:0] count_ff, count_in, count_eff, count_next;
   logic        done_ff, done_in, done_eff;
   logic [15:0] max_ff;
   logic [15:0] limit;
   logic        accept;
   logic        take;
   logic [7:0]  first_byte;
   logic [7:0]  attr;
   logic        last_hit;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   assign offset_eff  = req_tuser ? 5'd0  : offset_ff;
   assign pending_eff = req_tuser ? 1'b0  : pending_ff;
   assign count_eff   = req_tuser ? 16'd0 : count_ff;
   assign done_eff    = req_tuser ? 1'b0  : done_ff;
   assign take        = accept && !done_eff;

   assign first_byte = rec_ff[0];
   assign attr       = rec_ff[11];
   assign count_next = count_eff + 16'd1;
   assign limit      = (max_ff == 16'd0) ? 16'd1 : max_ff;
   assign last_hit   = (count_next == 16'd0) || (count_next >= limit);

   always_comb begin
      offset_in   = offset_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      q_push      = 1'b0;
      q_push_data = '0;
      if (accept) begin
         offset_in  = offset_eff;
         pending_in = pending_eff;
         count_in   = count_eff;
         done_in    = done_eff;
         if (!done_eff) begin
            offset_in = offset_eff + 5'd1;
            if (offset_eff == fdrp_pkg::RecLastOffset) begin
               if (first_byte == 8'd0) begin
                  q_push           = 1'b1;
                  q_push_data.kind = fdrp_pkg::KindEnd;
                  done_in          = 1'b1;
               end else if (first_byte == fdrp_pkg::MarkDeleted
                            || attr == fdrp_pkg::AttrVolume) begin
                  q_push = 1'b0;
               end else if ((attr & fdrp_pkg::AttrLongName) == fdrp_pkg::AttrLongName) begin
                  pending_in = 1'b1;
               end else begin
                  q_push                    = 1'b1;
                  q_push_data.kind          = fdrp_pkg::KindEntry;
                  q_push_data.entry_index   = count_eff;
                  q_push_data.last_entry    = last_hit;
                  q_push_data.had_long_name = pending_eff;
                  q_push_data.name_main     = {rec_ff[0], rec_ff[1], rec_ff[2], rec_ff[3],
                                               rec_ff[4], rec_ff[5], rec_ff[6], rec_ff[7]};
                  q_push_data.name_ext      = {rec_ff[8], rec_ff[9], rec_ff[10]};
                  q_push_data.attr          = attr;
                  q_push_data.cluster_hi    = {rec_ff[21], rec_ff[20]};
                  q_push_data.cluster_lo    = {rec_ff[27], rec_ff[26]};
                  q_push_data.size_bytes    = {req_tdata, rec_ff[30], rec_ff[29], rec_ff[28]};
                  pending_in                = 1'b0;
                  count_in                  = count_next;
                  done_in                   = last_hit;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= 5'd0;
         pending_ff <= 1'b0;
         count_ff   <= 16'd0;
         done_ff    <= 1'b0;
         max_ff     <= fdrp_pkg::MaxEntriesReset;
      end else begin
         offset_ff  <= offset_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         done_ff    <= done_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rec_ff[offset_eff] <= req_tdata;
      end
   end

endmodule

/* src/fdrp_queue.sv */
module fdrp_queue #(
   parameter int unsigned Depth = 2,
   parameter int unsigned Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             full,
   output logic             valid,
   output logic [Width-1:0] head_data,
   input  logic             pop
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   logic [Width-1:0]    mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CntFull);
   assign valid     = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/fdrp_back.sv */
module fdrp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  fdrp_pkg::rec_type                     q_data,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [fdrp_pkg::RspDataWidth-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   logic                                valid_ff, valid_in;
   logic [fdrp_pkg::RspDataWidth-1:0]   data_ff;
   logic                                kind_ff;
   logic                                last_ff;
   fdrp_pkg::rsp_fields_type            fields;
   logic [31:0]                         cluster_raw;
   logic                                load;

   assign load  = q_valid && (!valid_ff || rsp_tready);
   assign q_pop = load;

   assign cluster_raw = {q_data.cluster_hi, q_data.cluster_lo};

   always_comb begin
      fields               = '0;
      fields.entry_index   = q_data.entry_index;
      fields.name_main     = q_data.name_main;
      fields.name_ext      = q_data.name_ext;
      fields.dir_flag      = q_data.attr[fdrp_pkg::AttrDirBit];
      fields.had_long_name = q_data.had_long_name;
      fields.size_bytes    = q_data.size_bytes;
      fields.dot_kind      = fdrp_pkg::DotNone;
      if (q_data.name_main[63:56] == fdrp_pkg::DotChar) begin
         fields.dot_kind = (q_data.name_main[55:48] == fdrp_pkg::DotChar)
                           ? fdrp_pkg::DotDouble : fdrp_pkg::DotSingle;
      end
      if (q_data.kind == fdrp_pkg::KindEnd) begin
         fields.cluster_head = 32'd0;
      end else if (cluster_raw == 32'd0) begin
         fields.cluster_head = fdrp_pkg::ClusterRoot;
      end else begin
         fields.cluster_head = cluster_raw;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= fdrp_pkg::RspDataWidth'(fields);
         kind_ff <= q_data.kind;
         last_ff <= q_data.last_entry;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* src/fdrp_checker.sv */
`include "fat32_directory_record_parser_defines.svh"

module fdrp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fdrp_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   `FDRP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp beat changed while stalled")

   `FDRP_ASSERT_NOW(a_end_clean, rsp_tvalid && rsp_tuser == fdrp_pkg::KindEnd, rsp_tdata == '0 && !rsp_tlast, "end marker carries data")

   `FDRP_ASSERT_NOW(a_cluster_nonzero, rsp_tvalid && rsp_tuser == fdrp_pkg::KindEntry, rsp_tdata[139:108] != 32'd0, "entry with zero cluster head")

   `FDRP_ASSERT_NOW(a_dot_code, rsp_tvalid, rsp_tdata[107:106] == fdrp_pkg::DotNone || rsp_tdata[107:106] == fdrp_pkg::DotSingle || rsp_tdata[107:106] == fdrp_pkg::DotDouble, "bad dot kind")

endmodule

bind fat32_directory_record_parser fdrp_checker u_fdrp_checker (.*);
